// File: hdl/rational_arithmetic_unit_macros.svh
// Assertion macros for the rational arithmetic unit.
// Included by the modules that check their own sequencing.
`ifndef RATIONAL_ARITHMETIC_UNIT_MACROS_SVH
`define RATIONAL_ARITHMETIC_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define RAU_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");
`define RAU_ASSERT_RST(label, clk, prop) \
  label: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define RAU_ASSERT(label, clk, rst, prop)
`define RAU_ASSERT_RST(label, clk, prop)
`endif
`endif

// File: hdl/rau_pkg.sv
// Package for the rational arithmetic unit: field widths, mode and status codes.
// No dependencies.
`timescale 1ns / 1ps
package rau_pkg;
  localparam int unsigned WordBitsDefault = 32;
  localparam int unsigned NumBits = 32;
  localparam int unsigned DenBits = 31;
  localparam int unsigned WideBits = 64;

  typedef enum logic [2:0] {
    MODE_ADD = 3'd0, MODE_SUB = 3'd1, MODE_MUL = 3'd2, MODE_DIV = 3'd3,
    MODE_NEG = 3'd4, MODE_ABS = 3'd5, MODE_CMP = 3'd6, MODE_NOP = 3'd7
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK = 2'd0, ST_ZERO_DEN = 2'd1, ST_OVERFLOW = 2'd2, ST_SPARE = 2'd3
  } status_t;

  typedef struct packed {
    logic [2:0]  mode;
    logic signed [NumBits-1:0] left_num;
    logic [DenBits-1:0] left_den;
    logic signed [NumBits-1:0] right_num;
    logic [DenBits-1:0] right_den;
  } op_t;

  typedef struct packed {
    logic signed [NumBits-1:0] result_num;
    logic [DenBits-1:0] result_den;
    logic is_equal;
    logic is_less;
    logic [1:0] status;
  } res_t;
endpackage

// File: hdl/rau_if.sv
// Valid/ready channels for the rational-unit operation and result payloads.
// Depends on rau_pkg.
`timescale 1ns / 1ps
interface rau_op_if;
  import rau_pkg::*;
  logic valid;
  logic ready;
  op_t  data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface rau_res_if;
  import rau_pkg::*;
  logic valid;
  logic ready;
  res_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: hdl/rational_arithmetic_unit.sv
// Rational arithmetic unit: add, subtract, multiply, divide, negate, absolute
// and compare of fractions with gcd reduction.
// Depends on rau_pkg, rau_if and the assertion macro header.
//
// Usage: operands arrive on the op channel (valid/ready), one result leaves on
// the res channel. The block works on one transaction at a time; op.ready is
// high only while it is idle and the output register is empty.
// One shared 33x33 multiplier forms the cross products in states S_MUL0 to
// S_MUL3, and one shared 64-bit subtractor performs both the binary gcd
// (Stein's method, one shift or subtract per cycle) and the restoring divisions
// that reduce numerator and denominator (one quotient bit per cycle).
// Compare and the unused mode finish in S_COMB, a zero denominator in
// S_GCD_INIT; the other modes run through the gcd loop and both divisions.
// Reset (rst, synchronous) empties the output register and returns the
// sequencer to idle. If the receiver stalls, the result is held in the output
// register and no new transaction is taken until it leaves.
`timescale 1ns / 1ps
module rational_arithmetic_unit
  import rau_pkg::*;
#(
  parameter int unsigned WORD_BITS = WordBitsDefault
) (
  input logic clk,
  input logic rst,
  rau_op_if.sink op,
  rau_res_if.source res
);
  `include "rational_arithmetic_unit_macros.svh"

  typedef enum logic [3:0] {
    S_IDLE, S_MUL0, S_MUL1, S_MUL2, S_MUL3, S_COMB, S_GCD_INIT, S_GCD,
    S_GCD_FIX, S_DIVN, S_DIVD, S_CHECK, S_DONE
  } state_t;

  localparam logic signed [WideBits-1:0] WMax =
    WideBits'((64'd1 << (WORD_BITS - 1)) - 64'd1);
  localparam logic signed [WideBits-1:0] WMin = -WMax - 64'sd1;

  state_t state;
  op_t    opr;
  logic signed [WideBits-1:0] p0, p1, num, den;
  logic [WideBits-1:0] ga, gb;       // gcd operands
  logic [5:0] shift;                 // common power of two
  logic [WideBits-1:0] g;            // gcd
  logic [WideBits-1:0] quo, rem, dividend;
  logic [6:0] bitcnt;
  logic num_neg;
  logic [WideBits-1:0] qnum;
  res_t out_data;
  logic out_valid;

  // shared multiplier operands
  logic signed [NumBits:0] ma, mb;
  logic signed [2*NumBits+1:0] mfull;
  logic signed [WideBits-1:0] mprod;
  assign mfull = ma * mb;
  assign mprod = mfull[WideBits-1:0];

  always_comb begin
    ma = '0;
    mb = '0;
    case (state)
      S_MUL0: begin
        ma = (NumBits+1)'(opr.left_num);
        mb = {2'b00, opr.right_den};
      end
      S_MUL1: begin
        ma = (NumBits+1)'(opr.right_num);
        mb = {2'b00, opr.left_den};
      end
      S_MUL2: begin
        ma = {2'b00, opr.left_den};
        mb = (opr.mode == MODE_DIV) ? (NumBits+1)'(opr.right_num)
                                    : {2'b00, opr.right_den};
      end
      S_MUL3: begin
        ma = (NumBits+1)'(opr.left_num);
        mb = (NumBits+1)'(opr.right_num);
      end
      default: ;
    endcase
  end

  // shared subtractor: larger minus smaller in the gcd, trial subtract in division
  logic [WideBits-1:0] sub_a, sub_b, sub_y;
  logic [WideBits:0] rem_sh;
  assign rem_sh = {rem, dividend[WideBits-1]};
  always_comb begin
    sub_a = ga;
    sub_b = gb;
    if (state == S_DIVN || state == S_DIVD) begin
      sub_a = rem_sh[WideBits-1:0];
      sub_b = g;
    end else if (ga < gb) begin
      sub_a = gb;
      sub_b = ga;
    end
    sub_y = sub_a - sub_b;
  end
  logic rem_ge;
  assign rem_ge = rem_sh[WideBits] || (rem_sh[WideBits-1:0] >= g);

  logic op_fire, res_fire;
  assign op_fire = op.valid && op.ready;
  assign res_fire = res.valid && res.ready;
  assign op.ready = (state == S_IDLE) && !out_valid;
  assign res.valid = out_valid;
  assign res.data = out_data;

  function automatic logic [WideBits-1:0] mag(input logic signed [WideBits-1:0] v);
    mag = v[WideBits-1] ? WideBits'(-v) : v;
  endfunction

  logic signed [WideBits-1:0] rn, rd;
  assign rn = num_neg ? -$signed(qnum) : $signed(qnum);
  assign rd = $signed(quo);

  // sequencer, operand and result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (res_fire) out_valid <= 1'b0;
      case (state)
        S_IDLE: if (op_fire) begin
          opr <= op.data;
          state <= S_MUL0;
        end
        S_MUL0: begin p0 <= mprod; state <= S_MUL1; end
        S_MUL1: begin p1 <= mprod; state <= S_MUL2; end
        S_MUL2: begin den <= mprod; state <= S_MUL3; end
        S_MUL3: begin num <= mprod; state <= S_COMB; end
        S_COMB: begin
          case (opr.mode)
            MODE_ADD: begin
              out_data <= '0;
              num <= p0 + p1;
              state <= S_GCD_INIT;
            end
            MODE_SUB: begin
              out_data <= '0;
              num <= p0 - p1;
              state <= S_GCD_INIT;
            end
            MODE_MUL: begin
              out_data <= '0;
              state <= S_GCD_INIT;
            end
            MODE_DIV: begin
              out_data <= '0;
              num <= p0;
              state <= S_GCD_INIT;
            end
            MODE_NEG: begin
              out_data <= '0;
              num <= -WideBits'(opr.left_num);
              den <= WideBits'(opr.left_den);
              state <= S_GCD_INIT;
            end
            MODE_ABS: begin
              out_data <= '0;
              num <= mag(WideBits'(opr.left_num));
              den <= WideBits'(opr.left_den);
              state <= S_GCD_INIT;
            end
            MODE_CMP: begin
              out_data <= '{result_num: '0, result_den: '0,
                            is_equal: (opr.left_num == opr.right_num) &&
                                      (opr.left_den == opr.right_den),
                            is_less: p0 < p1, status: ST_OK};
              out_valid <= 1'b1;
              state <= S_IDLE;
            end
            default: begin
              out_data <= '0;
              out_valid <= 1'b1;
              state <= S_IDLE;
            end
          endcase
        end
        S_GCD_INIT: begin
          if (den == '0) begin
            out_data.status <= ST_ZERO_DEN;
            out_valid <= 1'b1;
            state <= S_IDLE;
          end else begin
            if (den[WideBits-1]) begin
              num <= -num;
              den <= -den;
            end
            ga <= mag(num);
            gb <= mag(den);
            shift <= '0;
            state <= S_GCD;
          end
        end
        // binary gcd: one shift or subtract per cycle
        S_GCD: begin
          if (ga == '0) begin
            g <= gb;
            state <= S_GCD_FIX;
          end else if (!ga[0] && !gb[0]) begin
            ga <= ga >> 1;
            gb <= gb >> 1;
            shift <= shift + 6'd1;
          end else if (!ga[0]) begin
            ga <= ga >> 1;
          end else if (!gb[0]) begin
            gb <= gb >> 1;
          end else if (ga >= gb) begin
            ga <= sub_y >> 1;
          end else begin
            gb <= sub_y >> 1;
          end
        end
        S_GCD_FIX: begin
          g <= g << shift;
          num_neg <= num[WideBits-1];
          dividend <= mag(num);
          rem <= '0;
          bitcnt <= '0;
          state <= S_DIVN;
        end
        // restoring division, one quotient bit per cycle
        S_DIVN, S_DIVD: begin
          quo <= {quo[WideBits-2:0], rem_ge};
          if (bitcnt == 7'(WideBits - 1)) begin
            bitcnt <= '0;
            rem <= '0;
            if (state == S_DIVN) begin
              qnum <= {quo[WideBits-2:0], rem_ge};
              dividend <= den;
              state <= S_DIVD;
            end else begin
              state <= S_CHECK;
            end
          end else begin
            rem <= rem_ge ? sub_y : rem_sh[WideBits-1:0];
            dividend <= dividend << 1;
            bitcnt <= bitcnt + 7'd1;
          end
        end
        S_CHECK: begin
          if (rn < WMin || rn > WMax || rd > WMax) begin
            out_data.status <= ST_OVERFLOW;
          end else begin
            out_data.result_num <= NumBits'(rn);
            out_data.result_den <= DenBits'(rd);
            out_data.status <= ST_OK;
          end
          out_valid <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `RAU_ASSERT(a_busy_not_ready, clk, rst, (state != S_IDLE) |-> !op.ready)
  `RAU_ASSERT(a_start, clk, rst, op_fire |=> (state == S_MUL0))
  `RAU_ASSERT(a_hold, clk, rst, (res.valid && !res.ready) |=> $stable(res.data))
  `RAU_ASSERT(a_one_out, clk, rst, (out_valid && state != S_IDLE) |-> 1'b0)
endmodule

// File: test/tb_top.sv
// Testbench for the rational arithmetic unit: directed and random fractions
// with a local predictor and in-order checking. Depends on rau_pkg, rau_if and rational_arithmetic_unit.
`timescale 1ns / 1ps
module tb_top;
  import rau_pkg::*;

  localparam int unsigned WB = WordBitsDefault;
  localparam int NumRandom = 1330;
  localparam longint CycleLimit = 2000000;

  logic clk = 1'b0;
  logic rst = 1'b1;

  rau_op_if  op_ch ();
  rau_res_if res_ch ();

  rational_arithmetic_unit #(.WORD_BITS(WB)) dut (
    .clk(clk), .rst(rst), .op(op_ch.sink), .res(res_ch.source)
  );

  always #4 clk = ~clk;

  op_t    pending_ops[$];
  res_t   expected_res[$];
  int     errors = 0;
  int     results_seen = 0;
  int     send_idle_pct = 38;
  int     recv_idle_pct = 58;
  int     hold_off = 0;
  int     ovf_seen = 0;
  int     zden_seen = 0;
  bit     stim_done = 0;
  bit     op_taken = 0;
  longint cycles = 0;

  // Euclid on magnitudes
  function automatic longint unsigned gcd_mag(longint unsigned x, longint unsigned y);
    longint unsigned t;
    while (y != 0) begin
      t = x % y;
      x = y;
      y = t;
    end
    return x;
  endfunction

  function automatic longint unsigned mag(longint v);
    return (v < 0) ? longint'(-v) : v;
  endfunction

  // Reduce n/d to lowest terms and range-check against the word
  function automatic res_t reduce_fraction(longint n, longint d);
    res_t r;
    longint g;
    longint wmax;
    longint wmin;
    r = '0;
    wmax = (longint'(1) <<< (WB - 1)) - 1;
    wmin = -wmax - 1;
    if (d == 0) begin
      r.status = ST_ZERO_DEN;
      return r;
    end
    g = longint'(gcd_mag(mag(n), mag(d)));
    n = n / g;
    d = d / g;
    if (d < 0) begin
      n = -n;
      d = -d;
    end
    if (n < wmin || n > wmax || d > wmax) begin
      r.status = ST_OVERFLOW;
      return r;
    end
    r.result_num = n[31:0];
    r.result_den = d[30:0];
    r.status = ST_OK;
    return r;
  endfunction

  function automatic res_t fraction_result(op_t o);
    res_t r;
    longint a;
    longint b;
    longint c;
    longint d;
    r = '0;
    a = longint'(o.left_num);
    b = longint'({1'b0, o.left_den});
    c = longint'(o.right_num);
    d = longint'({1'b0, o.right_den});
    case (mode_t'(o.mode))
      MODE_ADD: r = reduce_fraction(a * d + c * b, b * d);
      MODE_SUB: r = reduce_fraction(a * d - c * b, b * d);
      MODE_MUL: r = reduce_fraction(a * c, b * d);
      MODE_DIV: r = reduce_fraction(a * d, b * c);
      MODE_NEG: r = reduce_fraction(-a, b);
      MODE_ABS: r = reduce_fraction(a < 0 ? -a : a, b);
      MODE_CMP: begin
        r.is_equal = (a == c && b == d);
        r.is_less = (a * d < c * b);
      end
      default: r = '0;
    endcase
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d (t=%0t)", what, got, want, $time);
    errors++;
  endtask

  function automatic op_t make_op(mode_t m, logic [31:0] ln, logic [30:0] ld,
                                  logic [31:0] rn, logic [30:0] rd);
    op_t o;
    o.mode = m;
    o.left_num = ln;
    o.left_den = ld;
    o.right_num = rn;
    o.right_den = rd;
    return o;
  endfunction

  // Random numerator: small, full range or extreme
  function automatic logic [31:0] rand_num();
    case ($urandom_range(0, 5))
      0: return 32'(int'($urandom_range(0, 40)) - 20);
      1: return 32'h8000_0000;
      2: return 32'h7fff_ffff;
      3: return 32'(int'($urandom_range(0, 2000)) - 1000);
      default: return $urandom;
    endcase
  endfunction

  // Random denominator: zero occasionally, often small, sometimes full range or maximum
  function automatic logic [30:0] rand_den();
    case ($urandom_range(0, 9))
      0: return 31'd0;
      1: return 31'h7fff_ffff;
      2, 3, 4: return 31'($urandom_range(1, 12));
      5, 6: return 31'($urandom_range(1, 5000));
      default: return 31'($urandom);
    endcase
  endfunction

  // Drive transactions at the falling edge; advance only once the last one was taken
  always @(negedge clk) begin
    if (rst) begin
      op_ch.valid <= 1'b0;
      op_ch.data <= '0;
    end else if (!op_ch.valid || op_taken) begin
      if (pending_ops.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        op_ch.valid <= 1'b1;
        op_ch.data <= pending_ops.pop_front();
      end else begin
        op_ch.valid <= 1'b0;
      end
    end
  end

  // Receiver readiness, with an optional long hold-off
  always @(negedge clk) begin
    if (rst) begin
      res_ch.ready <= 1'b0;
    end else if (hold_off > 0) begin
      res_ch.ready <= 1'b0;
      hold_off <= hold_off - 1;
    end else begin
      res_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // Predict on acceptance, check on delivery
  always @(posedge clk) begin
    res_t want;
    res_t got;
    op_taken <= !rst && op_ch.valid && op_ch.ready;
    if (!rst) begin
      if (op_ch.valid && op_ch.ready)
        expected_res.push_back(fraction_result(op_ch.data));
      if (res_ch.valid && res_ch.ready) begin
        got = res_ch.data;
        results_seen++;
        if (expected_res.size() == 0) begin
          report_mismatch("unexpected result transaction", 1, 0);
        end else begin
          want = expected_res.pop_front();
          if (got.status == ST_OVERFLOW) ovf_seen++;
          if (got.status == ST_ZERO_DEN) zden_seen++;
          if (got.result_num !== want.result_num)
            report_mismatch("result_num", got.result_num, want.result_num);
          if (got.result_den !== want.result_den)
            report_mismatch("result_den", got.result_den, want.result_den);
          if (got.is_equal !== want.is_equal)
            report_mismatch("is_equal", got.is_equal, want.is_equal);
          if (got.is_less !== want.is_less)
            report_mismatch("is_less", got.is_less, want.is_less);
          if (got.status !== want.status)
            report_mismatch("status", got.status, want.status);
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("FAIL");
      $finish;
    end
  end

  // Stimulus and phase control
  initial begin
    op_t o;
    mode_t m;
    op_ch.valid = 1'b0;
    op_ch.data = '0;
    res_ch.ready = 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed: extremes, every mode, zero and overflow cases
    pending_ops.push_back(make_op(MODE_ADD, 32'd1, 31'd2, 32'd1, 31'd3));
    pending_ops.push_back(make_op(MODE_SUB, 32'd1, 31'd2, 32'd1, 31'd2));
    pending_ops.push_back(make_op(MODE_MUL, 32'h8000_0000, 31'd1, 32'h8000_0000, 31'd1));
    pending_ops.push_back(make_op(MODE_MUL, 32'h7fff_ffff, 31'h7fff_ffff, 32'd6, 31'd4));
    pending_ops.push_back(make_op(MODE_DIV, 32'd3, 31'd4, 32'd0, 31'd5));
    pending_ops.push_back(make_op(MODE_DIV, 32'hffff_fffd, 31'd4, 32'hffff_fffe, 31'd9));
    pending_ops.push_back(make_op(MODE_NEG, 32'h8000_0000, 31'd1, 32'd0, 31'd1));
    pending_ops.push_back(make_op(MODE_NEG, 32'h8000_0000, 31'd2, 32'd0, 31'd1));
    pending_ops.push_back(make_op(MODE_ABS, 32'h8000_0000, 31'd1, 32'd0, 31'd1));
    pending_ops.push_back(make_op(MODE_ABS, 32'hffff_fff6, 31'd4, 32'd0, 31'd1));
    pending_ops.push_back(make_op(MODE_CMP, 32'd2, 31'd4, 32'd1, 31'd2));
    pending_ops.push_back(make_op(MODE_CMP, 32'd7, 31'd3, 32'd7, 31'd3));
    pending_ops.push_back(make_op(MODE_CMP, 32'h8000_0000, 31'h7fff_ffff, 32'h7fff_ffff, 31'd1));
    pending_ops.push_back(make_op(MODE_ADD, 32'd5, 31'd0, 32'd1, 31'd1));
    pending_ops.push_back(make_op(MODE_NEG, 32'd5, 31'd0, 32'd1, 31'd1));
    pending_ops.push_back(make_op(MODE_ADD, 32'd0, 31'd7, 32'd0, 31'd9));
    pending_ops.push_back(make_op(MODE_ADD, 32'h7fff_ffff, 31'd1, 32'h7fff_ffff, 31'd1));
    pending_ops.push_back(make_op(MODE_SUB, 32'h8000_0000, 31'h7fff_ffff,
                                  32'h7fff_ffff, 31'h7fff_fffe));
    pending_ops.push_back(make_op(MODE_NOP, 32'hffff_ffff, 31'h7fff_ffff,
                                  32'hffff_ffff, 31'h7fff_ffff));
    pending_ops.push_back(make_op(MODE_CMP, 32'd0, 31'd0, 32'd0, 31'd0));

    // Random, three idling phases; long receiver hold-off in the first
    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 38 : (phase == 1) ? 58 : 0;
      recv_idle_pct = (phase == 0) ? 58 : (phase == 1) ? 38 : 0;
      for (int i = 0; i < NumRandom / 3; i++) begin
        m = mode_t'($urandom_range(0, 7));
        o = make_op(m, rand_num(), rand_den(), rand_num(), rand_den());
        if ($urandom_range(0, 3) == 0)
          o.right_num = o.left_num;
        pending_ops.push_back(o);
        if (phase == 0 && i == 40)
          hold_off = 2000;
      end
      while (pending_ops.size() > 0 || op_ch.valid) @(posedge clk);
    end

    while (expected_res.size() > 0) @(posedge clk);
    repeat (500) @(posedge clk);
    stim_done = 1;
    $display("covered %0d results over all seven modes plus the unused one,", results_seen);
    $display("  with %0d zero-denominator and %0d overflow outcomes", zden_seen, ovf_seen);
    if (errors == 0 && expected_res.size() == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end
endmodule

// File: sim.f
+incdir+hdl
hdl/rau_pkg.sv
hdl/rau_if.sv
hdl/rational_arithmetic_unit.sv
test/tb_top.sv
